FILE: rtl/mfrr_pkg.sv
// ----------------------------------------------------------------------------
// Frame rotate readout package
// Command codes and pixel constants shared by the readout core.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrr_pkg;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Leftmost pixel of a frame byte.
   localparam logic [7:0] PIXEL_MSB = 8'h80;

endpackage

`default_nettype wire

FILE: rtl/mfrr_ram.sv
// ----------------------------------------------------------------------------
// Single-port RAM
// Generic synchronous RAM with one address port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 5000
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata <= mem[addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mono_frame_rotate_readout_core.sv
// ----------------------------------------------------------------------------
// Mono frame rotate readout core
// A load is written when taken and does not raise busy. A straight
// request reads one frame byte and a rotated one eight, the source bytes
// coming one per cycle through the single frame memory port; busy is high
// until the answer is registered. The answer strobe lasts one cycle.
// Reset clears control state and rotation; frame memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_frame_rotate_readout_core #(
   parameter int SIDE = 200
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_cmd,
   input  wire logic [12:0] req_byte_addr,
   input  wire logic [7:0] req_load_byte,
   input  wire logic [7:0] req_gate,
   input  wire logic [4:0] req_column,
   output logic            rsp_valid,
   output logic [7:0]      rsp_panel_byte,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_rotate
);

   import mfrr_pkg::*;

   localparam int STRIDE = (SIDE + 7) / 8;
   localparam int DEPTH  = SIDE * STRIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int XW     = $clog2(SIDE);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [2:0]    step_ff, step_in;
   logic          rot_ff, rot_in;
   logic          oob_ff, oob_in;
   logic [2:0]    xbit_ff, xbit_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [7:0]    y_ff, y_in;
   logic          pend_ff, pend_in;
   logic          pend_zero_ff, pend_zero_in;
   logic [2:0]    pend_step_ff, pend_step_in;
   logic [7:0]    acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rotate_ff, rotate_in;

   logic          accept;
   logic          zero_now;
   logic          last_step;
   logic [XW-1:0] xv;
   logic          ram_we;
   logic          ram_re;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_rdata;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_panel_byte = rsp_byte_ff;

   // Source pixel column for a rotated request.
   assign xv = XW'(SIDE - 1 - 32'(req_gate));

   // A read slot contributes zero when the request lies outside the frame or its pixel row does.
   assign zero_now  = oob_ff || (rot_ff && (32'(y_ff) >= SIDE));
   assign last_step = !rot_ff || (step_ff == 3'd7);

   assign ram_we   = accept && (req_cmd == CMD_LOAD) && (32'(req_byte_addr) < DEPTH);
   assign ram_re   = (state_ff == ST_ISSUE) && !zero_now;
   assign ram_addr = busy ? addr_ff : AW'(req_byte_addr);

   mfrr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (req_load_byte),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rot_in       = rot_ff;
      oob_in       = oob_ff;
      xbit_in      = xbit_ff;
      addr_in      = addr_ff;
      y_in         = y_ff;
      pend_in      = 1'b0;
      pend_zero_in = zero_now;
      pend_step_in = step_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rotate_in    = rotate_ff;

      if (csr_valid && csr_ready) begin
         rotate_in = csr_rotate;
      end

      // Fold in the byte read in the previous cycle.
      if (pend_ff && !pend_zero_ff) begin
         if (rot_ff) begin
            if (ram_rdata[3'd7 - xbit_ff]) begin
               acc_in = acc_ff | (PIXEL_MSB >> pend_step_ff);
            end
         end else begin
            acc_in = ram_rdata;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_READ)) begin
               state_in = ST_ISSUE;
               step_in  = 3'd0;
               rot_in   = rotate_ff;
               acc_in   = 8'h00;
               xbit_in  = xv[2:0];
               y_in     = {req_column, 3'b000};
               oob_in   = (32'(req_gate) >= SIDE) ||
                          (!rotate_ff && (32'(req_column) >= STRIDE));
               if (rotate_ff) begin
                  addr_in = AW'(32'(req_column) * (8 * STRIDE) + 32'(xv >> 3));
               end else begin
                  addr_in = AW'(32'(req_gate) * STRIDE + 32'(req_column));
               end
            end
         end
         ST_ISSUE: begin
            pend_in = 1'b1;
            step_in = step_ff + 3'd1;
            y_in    = y_ff + 8'd1;
            addr_in = addr_ff + AW'(STRIDE);
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = ~acc_in;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rotate_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rotate_ff    <= rotate_in;
      end
      step_ff      <= step_in;
      rot_ff       <= rot_in;
      oob_ff       <= oob_in;
      xbit_ff      <= xbit_in;
      addr_ff      <= addr_in;
      y_ff         <= y_in;
      pend_zero_ff <= pend_zero_in;
      pend_step_ff <= pend_step_in;
      acc_ff       <= acc_in;
      rsp_byte_ff  <= rsp_byte_in;
   end

`ifndef SYNTH
   // A result strobe is never held high back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // Frame loads only reach the memory while no request is in progress.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("frame write during a request");

   // Every finished request produces exactly one result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> rsp_valid_ff)
      else $error("request finished without a result");

   // Read data is folded in only right after an issue slot.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ($past(state_ff) == ST_ISSUE))
      else $error("pending read without an issue slot");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Frame rotate readout core testbench
// Loads frame bytes and requests panel RAM bytes with rotation off and on.
// The bench computes every answer from its own copy of the frame and of the
// rotate setting. It also keeps track of which frame bytes have been loaded,
// so that no request ever reads a byte that was never written.
// ----------------------------------------------------------------------------
module tb;
   import mfrr_pkg::*;

   localparam int SIDE       = 200;
   localparam int STRIDE     = (SIDE + 7) / 8;
   localparam int DEPTH      = SIDE * STRIDE;
   localparam int ADDR_MAX   = 8191;
   localparam int QUIET_MAX  = 2000;
   localparam int SETTLE_CYC = 14;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = CMD_LOAD;
   logic [12:0] req_byte_addr = '0;
   logic [7:0]  req_load_byte = '0;
   logic [7:0]  req_gate = '0;
   logic [4:0]  req_column = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_panel_byte;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_rotate = 1'b0;

   // Checker side: the frame image and rotate setting seen at the ports.
   logic [7:0]  frame_img [DEPTH];
   logic        rotate_on = 1'b0;
   logic [7:0]  pending_bytes [$];
   int          mismatches = 0;
   int          quiet_cycles = 0;

   // Stimulus side: which bytes hold data, and the setting last written.
   bit          loaded [DEPTH];
   logic        rotate_sel = 1'b0;
   int          burst_left = 0;
   int          accepted_items = 0;

   mono_frame_rotate_readout_core #(.SIDE(SIDE)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_byte_addr  (req_byte_addr),
      .req_load_byte  (req_load_byte),
      .req_gate       (req_gate),
      .req_column     (req_column),
      .rsp_valid      (rsp_valid),
      .rsp_panel_byte (rsp_panel_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_rotate     (csr_rotate)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] image_byte(input int row, input int col);
      if (row >= SIDE || col >= STRIDE)
         return 8'h00;
      return frame_img[row * STRIDE + col];
   endfunction

   function automatic logic [7:0] expected_panel_byte(input int g, input int c);
      logic [7:0] black;
      int         x;
      black = 8'h00;
      if (g < SIDE) begin
         if (!rotate_on) begin
            black = image_byte(g, c);
         end else begin
            x = SIDE - 1 - g;
            // Pixel column x of eight successive rows, top row in the MSB.
            for (int s = 0; s < 8; s++) begin
               if ((image_byte(c * 8 + s, x / 8) & (PIXEL_MSB >> (x % 8))) != 8'h00)
                  black = black | (PIXEL_MSB >> s);
            end
         end
      end
      return ~black;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("tb: MISMATCH at %0t: %s, got %02h, expected %02h", $realtime, what, got,
               want);
      mismatches++;
   endtask

   // Checks each answer first, then takes in whatever transaction the same
   // edge accepted, so that the order of events within a step does not matter.
   always @(posedge clock) begin
      logic [7:0] want;
      logic       progress;
      progress = 1'b0;
      if (!reset) begin
         if (rsp_valid) begin
            progress = 1'b1;
            if (pending_bytes.size() == 0) begin
               report_mismatch("answer with no request waiting", rsp_panel_byte, 8'h00);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_panel_byte !== want)
                  report_mismatch("panel_byte", rsp_panel_byte, want);
            end
         end
         if (start && !busy) begin
            progress = 1'b1;
            if (req_cmd == CMD_LOAD) begin
               if (req_byte_addr < DEPTH)
                  frame_img[req_byte_addr] = req_load_byte;
            end else begin
               pending_bytes.push_back(expected_panel_byte(req_gate, req_column));
            end
         end
         if (csr_valid && csr_ready) begin
            progress = 1'b1;
            rotate_on = csr_rotate;
         end
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_MAX)
         @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   task automatic send_item(input logic cmd, input int addr, input int data,
                            input int g, input int c);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(20, 1)) @(posedge clock);
         burst_left = ($urandom_range(7) == 0) ? 64 : $urandom_range(24, 1);
      end
      burst_left--;
      start         <= 1'b1;
      req_cmd       <= cmd;
      req_byte_addr <= 13'(addr);
      req_load_byte <= 8'(data);
      req_gate      <= 8'(g);
      req_column    <= 5'(c);
      do @(posedge clock); while (busy);
      if (cmd == CMD_READ || addr < DEPTH)
         accepted_items++;
      if (cmd == CMD_LOAD && addr < DEPTH)
         loaded[addr] = 1'b1;
   endtask

   task automatic load_if_missing(input int addr);
      if (!loaded[addr])
         send_item(CMD_LOAD, addr, $urandom_range(255), $urandom_range(255),
                   $urandom_range(31));
   endtask

   // Loads every frame byte that a request at (g, c) will read.
   task automatic fill_sources(input int g, input int c);
      int x;
      if (g < SIDE) begin
         if (!rotate_sel) begin
            if (c < STRIDE)
               load_if_missing(g * STRIDE + c);
         end else begin
            x = SIDE - 1 - g;
            for (int s = 0; s < 8; s++) begin
               if (c * 8 + s < SIDE)
                  load_if_missing((c * 8 + s) * STRIDE + x / 8);
            end
         end
      end
   endtask

   task automatic send_read(input int g, input int c);
      send_item(CMD_READ, $urandom_range(ADDR_MAX), $urandom_range(255), g, c);
   endtask

   // Waits until every answer is in, then lets a load still in flight finish.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_rotate(input logic value);
      csr_valid  <= 1'b1;
      csr_rotate <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      rotate_sel = value;
   endtask

   task automatic test_straight_edges();
      send_item(CMD_LOAD, 0, 8'hFF, 0, 0);
      send_item(CMD_LOAD, DEPTH - 1, 8'h00, 255, 31);
      send_item(CMD_LOAD, 1, 8'hA5, 255, 31);
      // Loads beyond the store are dropped.
      send_item(CMD_LOAD, ADDR_MAX, 8'h5A, 0, 0);
      send_item(CMD_LOAD, DEPTH, 8'h3C, 0, 0);
      send_item(CMD_READ, ADDR_MAX, 8'hFF, 0, 0);
      send_item(CMD_READ, 0, 8'h00, SIDE - 1, STRIDE - 1);
      send_item(CMD_READ, ADDR_MAX, 8'hFF, 0, 1);
      // Outside the frame the answer is all white.
      send_read(SIDE, 0);
      send_read(255, 31);
      send_read(0, STRIDE);
      send_read(SIDE - 1, 31);
   endtask

   task automatic test_rotated_edges();
      fill_sources(SIDE - 1, 0);
      fill_sources(0, STRIDE - 1);
      send_read(SIDE - 1, 0);
      send_read(0, STRIDE - 1);
      // Rows past the bottom of the frame and gates past its edge read as white.
      send_read(5, STRIDE);
      send_read(0, 31);
      send_read(255, 3);
      send_read(SIDE, 31);
   endtask

   task automatic test_random_traffic(input int target);
      int first;
      int pick;
      int g;
      int c;
      first = accepted_items;
      while (accepted_items - first < target) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_item(CMD_LOAD, $urandom_range(DEPTH - 1), $urandom_range(255),
                      $urandom_range(255), $urandom_range(31));
         end else if (pick < 35) begin
            send_item(CMD_LOAD, $urandom_range(ADDR_MAX, DEPTH), $urandom_range(255),
                      $urandom_range(255), $urandom_range(31));
         end else if (pick < 88) begin
            g = $urandom_range(SIDE - 1);
            c = $urandom_range(STRIDE - 1);
            fill_sources(g, c);
            send_read(g, c);
         end else begin
            g = $urandom_range(255);
            c = $urandom_range(31);
            if (g < SIDE && c < STRIDE)
               g = $urandom_range(255, SIDE);
            fill_sources(g, c);
            send_read(g, c);
         end
      end
   endtask

   task automatic test_pause_for_drain(input int target);
      test_random_traffic(target / 2);
      drain_results();
      test_random_traffic(target - target / 2);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_rotate(1'b0);
      test_straight_edges();
      drain_results();
      write_rotate(1'b1);
      test_rotated_edges();
      test_random_traffic(350);
      drain_results();
      write_rotate(1'b0);
      test_pause_for_drain(350);
      drain_results();
      write_rotate(1'b1);
      test_random_traffic(350);
      drain_results();
      write_rotate(1'b0);
      test_random_traffic(250);
      drain_results();
      if (mismatches == 0 && pending_bytes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
